// ===== rtl/core/arsl_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// arsl_pkg
// Shared types and constants of the address range symbol lookup.
// ----------------------------------------------------------------------------
package arsl_pkg;

    localparam int MAX_ENTRIES = 1024;
    localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int ADDR_W      = 64;
    localparam int OUT_IDX_W   = 10;
    localparam int ENTRY_W     = 2 * ADDR_W + 1;
    localparam int IN_W        = 200;
    localparam int OUT_W       = 80;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_QUERY  = 2'd2,
        OP_NOP    = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOMATCH = 2'd1,
        ST_FULL    = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] idx;
    } t_rd;

    typedef struct packed {
        logic              found;
        logic [IDX_W-1:0]  idx;
        logic [ADDR_W-1:0] off;
    } t_match_res;

    // low bits of a table index as reported on the result item
    function automatic logic [OUT_IDX_W-1:0] to_out_idx(input logic [IDX_W-1:0] idx);
        logic [IDX_W+OUT_IDX_W-1:0] t;
        t = {{OUT_IDX_W{1'b0}}, idx};
        return t[OUT_IDX_W-1:0];
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/address_range_symbol_lookup.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// address_range_symbol_lookup
// Symbol table searched by address: append, clear and best-range query.
//
// Channel  Dir  Handshake              Payload
// s_*      in   i_s_tvalid/o_s_tready  opcode, query/entry fields (tdata)
// m_*      out  o_m_tvalid/i_m_tready  status, match_index, match_offset
//
// Clear, append and unused opcodes: result goes straight to the output reg.
// Query: one table read per cycle over the stored entries; the rate is set by
// the single read port of the entry RAM.
// Reset clears the entry count, the state and the output valid; the RAM is not swept.
// A held result stalls the next item and the end of a query.
// ----------------------------------------------------------------------------
module address_range_symbol_lookup
    import arsl_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_s_tvalid,
    output logic                  o_s_tready,
    // [1:0] opcode, [65:2] query_address, [129:66] entry_start,
    // [193:130] entry_length, [194] entry_is_function, [199:195] zero
    input  wire logic [IN_W-1:0]  i_s_tdata,
    output logic                  o_m_tvalid,
    input  wire logic             i_m_tready,
    // [1:0] status, [11:2] match_index, [75:12] match_offset, [79:76] zero
    output logic      [OUT_W-1:0] o_m_tdata
);

    t_state                r_state, n_state;
    logic [CNT_W-1:0]      r_count, n_count;
    logic [CNT_W-1:0]      r_rd_addr, n_rd_addr;
    logic [ADDR_W-1:0]     r_qaddr;
    logic                  r_out_valid, n_out_valid;
    t_status               r_out_status, n_out_status;
    logic [OUT_IDX_W-1:0]  r_out_idx, n_out_idx;
    logic [ADDR_W-1:0]     r_out_off, n_out_off;

    t_op                   w_op;
    logic [ADDR_W-1:0]     w_in_qaddr;
    logic [ENTRY_W-1:0]    w_entry;
    logic                  w_accept;
    logic                  w_out_free;
    logic                  w_full;
    logic                  w_we;
    logic                  w_start;
    t_rd                   w_rd;
    logic [ENTRY_W-1:0]    w_rdata;
    logic                  w_busy;
    t_match_res            w_res;

    assign w_op       = t_op'(i_s_tdata[1:0]);
    assign w_in_qaddr = i_s_tdata[ADDR_W+1:2];
    assign w_entry    = i_s_tdata[3*ADDR_W+2:ADDR_W+2];
    assign w_out_free = !r_out_valid || i_m_tready;
    assign o_s_tready = (r_state == S_IDLE) && w_out_free;
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_full     = (r_count == CNT_W'(MAX_ENTRIES));

    assign w_rd.valid = (r_state == S_SCAN) && (r_rd_addr < r_count);
    assign w_rd.idx   = r_rd_addr[IDX_W-1:0];

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_rd_addr    = r_rd_addr;
        n_out_valid  = r_out_valid && !i_m_tready;
        n_out_status = r_out_status;
        n_out_idx    = r_out_idx;
        n_out_off    = r_out_off;
        w_we         = 1'b0;
        w_start      = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_out_status = ST_OK;
                    n_out_idx    = '0;
                    n_out_off    = '0;
                    unique case (w_op)
                        OP_CLEAR: begin
                            n_count     = '0;
                            n_out_valid = 1'b1;
                        end
                        OP_APPEND: begin
                            n_out_valid = 1'b1;
                            if (w_full) begin
                                n_out_status = ST_FULL;
                            end else begin
                                w_we      = 1'b1;
                                n_count   = r_count + CNT_W'(1);
                                n_out_idx = to_out_idx(r_count[IDX_W-1:0]);
                            end
                        end
                        OP_QUERY: begin
                            w_start   = 1'b1;
                            n_rd_addr = '0;
                            n_state   = S_SCAN;
                        end
                        OP_NOP: begin
                            n_out_valid = 1'b1;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (w_rd.valid) begin
                    n_rd_addr = r_rd_addr + CNT_W'(1);
                end else if (!w_busy) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = w_res.found ? ST_OK : ST_NOMATCH;
                    n_out_idx    = w_res.found ? to_out_idx(w_res.idx) : '0;
                    n_out_off    = w_res.found ? w_res.off : '0;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_addr    <= n_rd_addr;
        r_out_status <= n_out_status;
        r_out_idx    <= n_out_idx;
        r_out_off    <= n_out_off;
        if (w_accept) begin
            r_qaddr <= w_in_qaddr;
        end
    end

    // entries only written while idle, so no write can meet a scan read
    arsl_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_ENTRIES)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_count[IDX_W-1:0]),
        .i_wdata (w_entry),
        .i_re    (w_rd.valid),
        .i_raddr (w_rd.idx),
        .o_rdata (w_rdata)
    );

    arsl_match u_match (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_rd    (w_rd),
        .i_rdata (w_rdata),
        .i_qaddr (r_qaddr),
        .o_busy  (w_busy),
        .o_res   (w_res)
    );

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {4'b0000, r_out_off, r_out_idx, r_out_status};

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_ENTRIES))
        else $error("entry count above table size");

    a_no_write_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !w_we)
        else $error("table write during a query");

    a_query_starts_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (w_op == OP_QUERY)) |=> (r_state == S_SCAN))
        else $error("query did not start a scan");

    a_nomatch_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_status != ST_OK)) |-> ((r_out_idx == '0) && (r_out_off == '0)))
        else $error("non-ok result carries index or offset");

endmodule
`default_nettype wire

// ===== rtl/core/arsl_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// arsl_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module arsl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/arsl_match.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// arsl_match
// Range check of each entry read during a scan and running best-match track.
// ----------------------------------------------------------------------------
module arsl_match
    import arsl_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire t_rd                i_rd,
    input  wire logic [ENTRY_W-1:0] i_rdata,
    input  wire logic [ADDR_W-1:0]  i_qaddr,
    output logic                    o_busy,
    output t_match_res              o_res
);

    logic              r_va;
    logic [IDX_W-1:0]  r_idx_a;
    logic              r_vb;
    logic              r_hit_b;
    logic [ADDR_W-1:0] r_off_b;
    logic [IDX_W-1:0]  r_idx_b;
    logic              r_found;
    logic [IDX_W-1:0]  r_best_idx;
    logic [ADDR_W-1:0] r_best_off;

    logic [ADDR_W-1:0] w_start;
    logic [ADDR_W-1:0] w_len;
    logic              w_fn;
    logic [ADDR_W-1:0] w_off;
    logic              w_hit;
    logic              w_better;

    assign w_start  = i_rdata[ADDR_W-1:0];
    assign w_len    = i_rdata[2*ADDR_W-1:ADDR_W];
    assign w_fn     = i_rdata[2*ADDR_W];
    assign w_off    = i_qaddr - w_start;
    assign w_hit    = w_fn && (i_qaddr >= w_start) && (w_off < w_len);
    // strict compare keeps the lowest index on a tie
    assign w_better = r_vb && r_hit_b && (!r_found || (r_off_b < r_best_off));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va    <= 1'b0;
            r_vb    <= 1'b0;
            r_found <= 1'b0;
        end else begin
            r_va <= i_rd.valid;
            r_vb <= r_va;
            if (i_start) begin
                r_found <= 1'b0;
            end else if (w_better) begin
                r_found <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx_a <= i_rd.idx;
        r_hit_b <= w_hit;
        r_off_b <= w_off;
        r_idx_b <= r_idx_a;
        if (w_better) begin
            r_best_idx <= r_idx_b;
            r_best_off <= r_off_b;
        end
    end

    assign o_busy      = r_va | r_vb;
    assign o_res.found = r_found;
    assign o_res.idx   = r_best_idx;
    assign o_res.off   = r_best_off;

endmodule
`default_nettype wire
